@@ src/keyframe_linear_sampler_assert.svh @@
// Assertion macros for the keyframe linear sampler.
`ifndef KEYFRAME_LINEAR_SAMPLER_ASSERT_SVH
`define KEYFRAME_LINEAR_SAMPLER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define KLS_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define KLS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

@@ src/kls_pkg.sv @@
// Shared types and constants of the keyframe linear sampler.
package kls_pkg;
    localparam int KEYS_MAX = 256;
    localparam int IDX_W    = $clog2(KEYS_MAX);
    localparam int CNT_W    = IDX_W + 1;
    localparam int FUNC_LOAD   = 0;
    localparam int FUNC_SAMPLE = 1;
    localparam logic [0:0] CFG_KEY_COUNT = 1'b0;
    localparam logic [0:0] CFG_MIN_SPAN  = 1'b1;

    // Classified command between front and back
    typedef struct packed {
        logic                func;
        logic [IDX_W-1:0]    key_index;
        logic [31:0]         key_time;
        logic signed [31:0]  key_x;
        logic signed [31:0]  key_y;
        logic signed [31:0]  key_z;
        logic [31:0]         sample_time;
    } t_cmd;
endpackage

@@ src/keyframe_linear_sampler.sv @@
// Top level of the keyframe linear sampler.
// Channel   Dir  tdata fields (low bit up)                     tuser
// s_axis    in   key_index, key_time, key_x, key_y, key_z,      func
//                sample_time (168 bits)
// m_axis    out  out_x, out_y, out_z (96 bits)                  no_keys
// A load writes its key into the key memory when the back end accepts it. A
// sample scans keys in order, then reads and checks the segment, runs the
// bit-serial divider when the time lies inside it, and blends.
// Reset is synchronous; the key memory is not cleared.
// A held result blocks the next item; the input queue keeps accepting until its two entries are full.
module keyframe_linear_sampler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key_index[7:0], key_time[39:8], key_x[71:40], key_y[103:72],
    // key_z[135:104], sample_time[167:136]
    input  logic [167:0] s_axis_tdata,
    // func
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // no_keys
    output logic         m_axis_tuser,
    input  logic         i_cfg_we,
    input  logic [0:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    `include "keyframe_linear_sampler_assert.svh"

    logic [8:0]    r_key_count;
    logic [15:0]   r_min_span;
    kls_pkg::t_cmd w_cmd_in, w_cmd_q;
    logic          w_q_valid, w_q_ready;
    logic signed [31:0] w_x, w_y, w_z;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_count <= 9'd0;
            r_min_span  <= 16'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kls_pkg::CFG_KEY_COUNT: r_key_count <= i_cfg_data[8:0];
                kls_pkg::CFG_MIN_SPAN:  r_min_span  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cmd_in.func        = s_axis_tuser;
    assign w_cmd_in.key_index   = s_axis_tdata[7:0];
    assign w_cmd_in.key_time    = s_axis_tdata[39:8];
    assign w_cmd_in.key_x       = s_axis_tdata[71:40];
    assign w_cmd_in.key_y       = s_axis_tdata[103:72];
    assign w_cmd_in.key_z       = s_axis_tdata[135:104];
    assign w_cmd_in.sample_time = s_axis_tdata[167:136];

    kls_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(w_cmd_in),
        .o_valid(w_q_valid), .i_ready(w_q_ready), .o_cmd(w_cmd_q)
    );

    kls_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_q_valid), .o_ready(w_q_ready), .i_cmd(w_cmd_q),
        .i_key_count(r_key_count), .i_min_span(r_min_span),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_x(w_x), .o_y(w_y), .o_z(w_z), .o_no_keys(m_axis_tuser)
    );
    assign m_axis_tdata = {w_z, w_y, w_x};

    // No-keys result carries zero values
    `KLS_ASSERT_IMP(a_nokeys_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 96'd0)
    // A stalled result holds
    `KLS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    // Back end takes nothing while a result waits
    `KLS_ASSERT_IMP(a_no_take, i_clk, i_rst_n, m_axis_tvalid, !w_q_ready)
endmodule

@@ src/kls_front.sv @@
// Front: input acceptance and two-entry command queue.
module kls_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  kls_pkg::t_cmd  i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output kls_pkg::t_cmd  o_cmd
);
    kls_pkg::t_cmd r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    // Queue pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // Queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_cmd;
    end
endmodule

@@ src/kls_div.sv @@
// Restoring divider: 48-bit numerator by 32-bit divisor, one bit a cycle.
module kls_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_done,
    output logic [15:0] o_quo
);
    logic [32:0] r_rem;
    logic [47:0] r_num;
    logic [15:0] r_quo;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] w_sh;
    logic [33:0] w_diff;

    assign w_sh   = {r_rem[31:0], r_num[47]};
    assign w_diff = {1'b0, w_sh} - {2'b00, i_den};
    assign o_quo  = r_quo;

    // One quotient bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd0;
                r_rem  <= '0;
                r_num  <= {i_num, 16'd0};
            end else if (r_busy) begin
                r_num <= {r_num[46:0], 1'b0};
                if (!w_diff[33]) begin
                    r_rem <= w_diff[32:0];
                    r_quo <= {r_quo[14:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_quo <= {r_quo[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd47) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

@@ src/kls_back.sv @@
// Back: key memory, segment search, divide and blend sequencer.
module kls_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  kls_pkg::t_cmd         i_cmd,
    input  logic [8:0]            i_key_count,
    input  logic [15:0]           i_min_span,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic signed [31:0]    o_x,
    output logic signed [31:0]    o_y,
    output logic signed [31:0]    o_z,
    output logic                  o_no_keys
);
    localparam int IW = kls_pkg::IDX_W;
    localparam int CW = kls_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCH_W, S_RD0, S_RD1, S_RD2, S_CHK, S_DIV,
        S_MUL, S_ADD, S_OUT
    } t_state;

    logic [31:0]        r_tmem [kls_pkg::KEYS_MAX];
    logic [95:0]        r_vmem [kls_pkg::KEYS_MAX];
    logic [31:0]        r_tq;
    logic [95:0]        r_vq;
    logic [IW-1:0]      w_raddr;
    t_state             r_st;
    logic [CW-1:0]      r_n, r_lo, r_hi;
    logic [31:0]        r_t, r_t0, r_t1;
    logic [95:0]        r_v0, r_v1;
    logic [16:0]        r_f;
    logic signed [32:0] r_d [3];
    logic signed [50:0] r_p [3];
    logic [1:0]         r_c;
    logic               w_div_start, w_div_done;
    logic [15:0]        w_quo;
    logic [31:0]        w_span;
    logic [CW-1:0]      w_n;

    assign w_n    = (i_key_count > 9'(kls_pkg::KEYS_MAX)) ? CW'(kls_pkg::KEYS_MAX)
                                                          : CW'(i_key_count);
    assign w_span = r_t1 - r_t0;
    assign o_ready = (r_st == S_IDLE) && !o_valid;

    // Read address by state
    always_comb begin
        case (r_st)
            S_SRCH:  w_raddr = r_lo[IW-1:0];
            S_RD0:   w_raddr = r_lo[IW-1:0];
            S_RD1:   w_raddr = IW'(r_lo + CW'(1));
            default: w_raddr = '0;
        endcase
    end

    // Key memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready && i_cmd.func == 1'(kls_pkg::FUNC_LOAD)) begin
            r_tmem[i_cmd.key_index] <= i_cmd.key_time;
            r_vmem[i_cmd.key_index] <= {i_cmd.key_z, i_cmd.key_y, i_cmd.key_x};
        end
        r_tq <= r_tmem[w_raddr];
        r_vq <= r_vmem[w_raddr];
    end

    kls_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_div_start),
        .i_num(r_t - r_t0), .i_den(w_span), .o_done(w_div_done), .o_quo(w_quo)
    );
    assign w_div_start = (r_st == S_CHK) && (r_t > r_t0) && (r_t < r_t1)
                         && !(r_t1 < r_t0 || w_span < {16'd0, i_min_span}
                              || r_t1 == r_t0);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            o_valid <= 1'b0;
        end else begin
            if (o_valid && i_ready) o_valid <= 1'b0;
            case (r_st)
                S_IDLE: begin
                    if (i_valid && o_ready && i_cmd.func == 1'(kls_pkg::FUNC_SAMPLE)) begin
                        r_t <= i_cmd.sample_time;
                        r_n <= w_n;
                        o_no_keys <= 1'b0;
                        if (w_n == '0) begin
                            {o_z, o_y, o_x} <= '0;
                            o_no_keys <= 1'b1;
                            o_valid   <= 1'b1;
                        end else if (w_n == CW'(1)) begin
                            r_lo <= '0;
                            r_f  <= '0;
                            r_st <= S_RD0;
                        end else begin
                            // scan j = 1..n-1 in order for the first t < time[j]
                            r_lo  <= CW'(1);
                            r_hi  <= w_n - CW'(1);
                            r_st  <= S_SRCH;
                        end
                    end
                end
                S_SRCH: r_st <= S_SRCH_W;
                S_SRCH_W: begin
                    if (r_t < r_tq || r_lo >= r_hi) begin
                        // r_lo is the end key, or n-1 when none
                        r_lo <= r_lo - CW'(1);
                        r_st <= S_RD0;
                    end else begin
                        r_lo <= r_lo + CW'(1);
                        r_st <= S_SRCH;
                    end
                end
                S_RD0: r_st <= S_RD1;
                S_RD1: begin
                    r_t0 <= r_tq;
                    r_v0 <= r_vq;
                    r_st <= S_RD2;
                end
                S_RD2: begin
                    r_t1 <= r_tq;
                    r_v1 <= r_vq;
                    if (r_n == CW'(1)) begin
                        {o_z, o_y, o_x} <= r_v0;
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end else begin
                        r_st <= S_CHK;
                    end
                end
                S_CHK: begin
                    if (r_t1 < r_t0 || w_span < {16'd0, i_min_span} || r_t1 == r_t0) begin
                        {o_z, o_y, o_x} <= r_v0;
                        o_valid <= 1'b1;
                        r_st    <= S_IDLE;
                    end else if (r_t <= r_t0) begin
                        r_f  <= 17'd0;
                        r_st <= S_MUL;
                    end else if (r_t >= r_t1) begin
                        r_f  <= 17'h10000;
                        r_st <= S_MUL;
                    end else begin
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_f  <= {1'b0, w_quo};
                        r_st <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_c <= 2'd0;
                    for (int k = 0; k < 3; k++) begin
                        r_d[k] <= $signed({r_v1[32*k+31], r_v1[32*k +: 32]})
                                - $signed({r_v0[32*k+31], r_v0[32*k +: 32]});
                    end
                    r_st <= S_ADD;
                end
                S_ADD: begin
                    // one component product per cycle
                    r_p[r_c] <= r_d[r_c] * $signed({1'b0, r_f});
                    r_c <= r_c + 2'd1;
                    if (r_c == 2'd2) r_st <= S_OUT;
                end
                S_OUT: begin
                    o_x <= 32'($signed(r_v0[31:0])  + (r_p[0] >>> 16));
                    o_y <= 32'($signed(r_v0[63:32]) + (r_p[1] >>> 16));
                    o_z <= 32'($signed(r_v0[95:64]) + (r_p[2] >>> 16));
                    o_valid <= 1'b1;
                    r_st    <= S_IDLE;
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
